[sv/ptkl_pkg.sv]
package ptkl_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned LIMIT_W  = 5;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;
  localparam logic [1:0] FUNC_IGNORE = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [15:0]        handle;
    logic signed [31:0] rate;
    logic [15:0]        match;
  } entry_t;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] cls;
    entry_t     entry;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    entry_t              entry;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } res_t;

endpackage

[sv/ptkl_engine.sv]
module ptkl_engine
  import ptkl_pkg::*;
#(
  parameter int LIST_CAPACITY = 16,
  parameter int NUM_CLASSES   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  req_t               req_i,
  input  logic [LIMIT_W-1:0] top_limit_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               res_ready_i
);

  // only classes reachable through the 3-bit class field get storage
  localparam int NCLS  = (NUM_CLASSES < 8) ? NUM_CLASSES : 8;
  localparam int CLS_W = (NCLS > 1) ? $clog2(NCLS) : 1;
  localparam int IDX_W = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int DEPTH = NCLS << IDX_W;
  localparam int ADDR_W = CLS_W + IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_REM  = 3'd2;
  localparam logic [2:0] S_DUMP = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CLS_W-1:0]    cls_q, cls_d;
  entry_t              ne_q, ne_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    rcnt_q, rcnt_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                full_q, full_d;
  logic                first_q, first_d;
  logic                found_q, found_d;

  entry_t              mem [DEPTH];
  entry_t              rd_data_q;
  logic                rd_en, wr_en;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  entry_t              wr_data;

  logic [CNT_W-1:0]    cnt_mem_q [NCLS];
  logic                cnt_we;
  logic [CNT_W-1:0]    cnt_wdata;

  logic [CLS_W-1:0]    req_cls;
  logic [CNT_W-1:0]    cnt_rd, rdcnt_m1;
  logic [CNT_W-1:0]    idx_m1, idx_m2, idx_p1;
  logic [CNT_W-1:0]    cnt_p1, cnt_m1, res_cnt;
  logic [LIM_W-1:0]    lim_ext, lim_cap, elim, cnt_rd_ext, res_cnt_ext;
  logic                less, hit, found_now;

  assign req_cls  = req_i.cls[CLS_W-1:0];
  assign cnt_rd   = cnt_mem_q[req_cls];
  assign rdcnt_m1 = cnt_rd - CNT_W'(1);
  assign idx_m1   = idx_q - CNT_W'(1);
  assign idx_m2   = idx_q - CNT_W'(2);
  assign idx_p1   = idx_q + CNT_W'(1);
  assign cnt_p1   = cnt_q + CNT_W'(1);
  assign cnt_m1   = cnt_q - CNT_W'(1);

  // zero acts as one, anything above capacity acts as capacity
  assign lim_ext    = LIM_W'(top_limit_i);
  assign lim_cap    = LIM_W'(LIST_CAPACITY);
  assign elim       = (lim_ext == '0) ? LIM_W'(1) : ((lim_ext > lim_cap) ? lim_cap : lim_ext);
  assign cnt_rd_ext = LIM_W'(cnt_rd);

  // shared compare unit
  assign less = rd_data_q.rate < ne_q.rate;
  assign hit  = rd_data_q.handle == ne_q.handle;
  assign found_now = found_q | hit;

  assign res_cnt     = (state_q == S_DUMP) ? cnt_q : rcnt_q;
  assign res_cnt_ext = LIM_W'(res_cnt);
  assign busy_o      = state_q != S_IDLE;

  always_comb begin
    state_d  = state_q;
    cls_d    = cls_q;
    ne_d     = ne_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    rcnt_d   = rcnt_q;
    status_d = status_q;
    full_d   = full_q;
    first_d  = first_q;
    found_d  = found_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = ne_q;
    cnt_we   = 1'b0;
    cnt_wdata = cnt_q;
    res_valid_o  = 1'b0;
    res_o.status = status_q;
    res_o.entry  = '0;
    res_o.count  = res_cnt_ext[COUNT_W-1:0];
    res_o.last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cls_d   = req_cls;
          ne_d    = req_i.entry;
          cnt_d   = cnt_rd;
          full_d  = cnt_rd_ext >= elim;
          first_d = 1'b1;
          found_d = 1'b0;
          case (req_i.func)
            FUNC_INSERT: begin
              // walk up from the tail, one entry per cycle
              idx_d   = cnt_rd;
              state_d = S_INS;
              if (cnt_rd != '0) begin
                rd_en   = 1'b1;
                rd_addr = {req_cls, rdcnt_m1[IDX_W-1:0]};
              end
            end
            FUNC_REMOVE: begin
              idx_d = '0;
              if (cnt_rd == '0) begin
                status_d = ST_NOT_FOUND;
                rcnt_d   = '0;
                state_d  = S_RES;
              end else begin
                rd_en   = 1'b1;
                rd_addr = {req_cls, IDX_W'(0)};
                state_d = S_REM;
              end
            end
            FUNC_DUMP: begin
              idx_d = '0;
              if (cnt_rd == '0) begin
                status_d = ST_EMPTY;
                rcnt_d   = '0;
                state_d  = S_RES;
              end else begin
                rd_en   = 1'b1;
                rd_addr = {req_cls, IDX_W'(0)};
                state_d = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS: begin
        first_d = 1'b0;
        if (idx_q == '0) begin
          wr_en    = 1'b1;
          wr_addr  = {cls_q, IDX_W'(0)};
          wr_data  = ne_q;
          cnt_we   = 1'b1;
          cnt_wdata = full_q ? cnt_q : cnt_p1;
          rcnt_d   = full_q ? cnt_q : cnt_p1;
          status_d = ST_INSERTED;
          state_d  = S_RES;
        end else if (first_q && full_q) begin
          // full list: new rate must beat the lowest, which is dropped
          if (!less) begin
            status_d = ST_REJECTED;
            rcnt_d   = cnt_q;
            state_d  = S_RES;
          end else begin
            idx_d = idx_m1;
            if (idx_m1 != '0) begin
              rd_en   = 1'b1;
              rd_addr = {cls_q, idx_m2[IDX_W-1:0]};
            end
          end
        end else if (less) begin
          wr_en   = 1'b1;
          wr_addr = {cls_q, idx_q[IDX_W-1:0]};
          wr_data = rd_data_q;
          idx_d   = idx_m1;
          if (idx_m1 != '0) begin
            rd_en   = 1'b1;
            rd_addr = {cls_q, idx_m2[IDX_W-1:0]};
          end
        end else begin
          wr_en    = 1'b1;
          wr_addr  = {cls_q, idx_q[IDX_W-1:0]};
          wr_data  = ne_q;
          cnt_we   = 1'b1;
          cnt_wdata = full_q ? cnt_q : cnt_p1;
          rcnt_d   = full_q ? cnt_q : cnt_p1;
          status_d = ST_INSERTED;
          state_d  = S_RES;
        end
      end

      S_REM: begin
        // once the handle is found, every later entry moves up one place
        found_d = found_now;
        if (found_q) begin
          wr_en   = 1'b1;
          wr_addr = {cls_q, idx_m1[IDX_W-1:0]};
          wr_data = rd_data_q;
        end
        if (idx_p1 == cnt_q) begin
          state_d = S_RES;
          if (found_now) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_m1;
            rcnt_d    = cnt_m1;
            status_d  = ST_REMOVED;
          end else begin
            rcnt_d   = cnt_q;
            status_d = ST_NOT_FOUND;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = {cls_q, idx_p1[IDX_W-1:0]};
          idx_d   = idx_p1;
        end
      end

      S_DUMP: begin
        res_valid_o  = 1'b1;
        res_o.status = ST_ENTRY;
        res_o.entry  = rd_data_q;
        res_o.last   = idx_p1 == cnt_q;
        if (res_ready_i) begin
          if (idx_p1 == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = {cls_q, idx_p1[IDX_W-1:0]};
            idx_d   = idx_p1;
          end
        end
      end

      S_RES: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q    <= cls_d;
    ne_q     <= ne_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    rcnt_q   <= rcnt_d;
    status_q <= status_d;
    full_q   <= full_d;
    first_q  <= first_d;
    found_q  <= found_d;
  end

  // entry storage, one write and one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCLS; i++) begin
        cnt_mem_q[i] <= '0;
      end
    end else if (cnt_we) begin
      cnt_mem_q[cls_q] <= cnt_wdata;
    end
  end

endmodule

[sv/per_class_top_k_ranked_list_unit.sv]
// insert: entries are moved down one place from the tail until the new entry's place is found
// remove: one pass over the list, one entry per cycle
// dump: one result per cycle while the output does not stall; an empty list gives a single empty result
// one request at a time; in_stall_o is high while the engine is busy
// reset: class counts cleared, top_limit set to 16, entry memory not cleared
module per_class_top_k_ranked_list_unit
  import ptkl_pkg::*;
#(
  parameter int LIST_CAPACITY = 16,
  parameter int NUM_CLASSES   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [2:0]          class_index_i,
  input  logic [15:0]         item_handle_i,
  input  logic signed [31:0]  item_rate_i,
  input  logic [15:0]         match_handle_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [15:0]         out_handle_o,
  output logic signed [31:0]  out_rate_o,
  output logic [15:0]         out_match_o,
  output logic [COUNT_W-1:0]  entry_count_o,
  output logic                is_last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LIMIT_W-1:0]  cfg_top_limit_i
);

  logic [LIMIT_W-1:0] top_limit_q;
  logic               busy;
  logic               in_accept;
  logic               req_valid;
  req_t               req;
  logic               res_valid;
  res_t               res;
  logic               slot_free;
  logic               out_valid_q;
  res_t               out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_limit_q <= LIMIT_W'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      top_limit_q <= cfg_top_limit_i;
    end
  end

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  // unknown func and out-of-range class are taken and dropped
  assign req_valid  = in_accept && (func_i != FUNC_IGNORE) && (int'(class_index_i) < NUM_CLASSES);

  assign req.func         = func_i;
  assign req.cls          = class_index_i;
  assign req.entry.handle = item_handle_i;
  assign req.entry.rate   = item_rate_i;
  assign req.entry.match  = match_handle_i;

  ptkl_engine #(
    .LIST_CAPACITY(LIST_CAPACITY),
    .NUM_CLASSES  (NUM_CLASSES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_i      (req),
    .top_limit_i(top_limit_q),
    .busy_o     (busy),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(slot_free)
  );

  // output register
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign out_handle_o  = out_q.entry.handle;
  assign out_rate_o    = out_q.entry.rate;
  assign out_match_o   = out_q.entry.match;
  assign entry_count_o = out_q.count;
  assign is_last_o     = out_q.last;

`ifndef SYNTHESIS
  a_req_makes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid |=> busy)
    else $error("request accepted but engine did not start");

  a_result_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> busy)
    else $error("result offered while engine idle");

  a_single_results_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_ENTRY)) |-> is_last_o)
    else $error("non-dump result not marked last");

  a_empty_has_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |-> (entry_count_o == '0))
    else $error("empty dump with nonzero count");
`endif

endmodule
